>>> sv/dwc_pkg.sv
// Shared types, constants and codes of the depthwise convolution stream core.
package dwc_pkg;

	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int MAX_WIDTH_DEF  = 256;

	localparam int KS_W    = 3;   // kernel_size, stride, padding
	localparam int DIM_W   = 9;   // in_height, in_width
	localparam int NUM_W   = 11;  // signed working width of plane coordinates
	localparam int SMP_W   = 16;
	localparam int BIAS_W  = 32;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 40;
	localparam int COORD_W = 8;
	localparam int TAPI_W  = 6;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 56;
	localparam int NDIV    = 5;

	// divider lanes
	localparam int DIV_ROWS = 0;  // output rows of the plane
	localparam int DIV_COLS = 1;  // output columns of the plane
	localparam int DIV_TROW = 2;  // window row hit by this sample row
	localparam int DIV_TCOL = 3;  // window column hit by this sample column
	localparam int DIV_SLOT = 4;  // line store row slot of the sample row

	typedef logic        [NUM_W-1:0] num_t;
	typedef logic signed [NUM_W-1:0] snum_t;

	typedef enum logic [2:0] {
		REG_KERNEL  = 3'd0,
		REG_STRIDE  = 3'd1,
		REG_PADDING = 3'd2,
		REG_HEIGHT  = 3'd3,
		REG_WIDTH   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_WEIGHT = 2'd1,
		KIND_BIAS   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KS_W-1:0]  k;
		logic [KS_W-1:0]  s;
		logic [KS_W-1:0]  p;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
	} cfg_t;

	typedef struct packed {
		num_t            quo;
		logic [KS_W-1:0] rem;
	} div_res_t;

	typedef struct packed {
		logic issue;  // a tap read goes out this cycle
		logic use_tap;  // the tap lies inside the plane
		logic init;   // load the accumulator with the bias
	} mac_ctl_t;

endpackage

>>> sv/dwc_div.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module dwc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  dwc_pkg::num_t         num,
	input  logic [dwc_pkg::KS_W-1:0] den,
	output logic                  done,
	output dwc_pkg::div_res_t     res
);
	import dwc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	num_t             n_q;
	logic [KS_W-1:0]  r_q;
	logic [KS_W-1:0]  d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [KS_W:0]    trial;
	logic [KS_W:0]    diff;
	logic             ge;

	assign trial = {r_q, n_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = ge ? (trial - {1'b0, d_q}) : trial;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (run_q) begin
			n_q <= {n_q[NUM_W-2:0], ge};
			r_q <= diff[KS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(NUM_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	assign done    = done_q;
	assign res.quo = n_q;
	assign res.rem = r_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (d_q != '0) |-> (r_q < d_q))
		else $error("divider remainder not below divisor");

endmodule

>>> sv/dwc_cfg.sv
// APB register file with the clamped working configuration.
module dwc_cfg #(
	parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF,
	parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dwc_pkg::PADDR_W-1:0] paddr,
	input  logic [dwc_pkg::PDATA_W-1:0] pwdata,
	output logic [dwc_pkg::PDATA_W-1:0] prdata,
	output dwc_pkg::cfg_t               eff
);
	import dwc_pkg::*;

	logic [KS_W-1:0]  k_q, s_q, p_q;
	logic [DIM_W-1:0] h_q, w_q;
	logic [KS_W-1:0]  k1;
	reg_idx_t         idx;

	assign idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KS_W'(3);
			s_q <= KS_W'(1);
			p_q <= KS_W'(1);
			h_q <= DIM_W'(256);
			w_q <= DIM_W'(256);
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_KERNEL:  k_q <= pwdata[KS_W-1:0];
				REG_STRIDE:  s_q <= pwdata[KS_W-1:0];
				REG_PADDING: p_q <= pwdata[KS_W-1:0];
				REG_HEIGHT:  h_q <= pwdata[DIM_W-1:0];
				REG_WIDTH:   w_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KERNEL:  prdata = PDATA_W'(k_q);
			REG_STRIDE:  prdata = PDATA_W'(s_q);
			REG_PADDING: prdata = PDATA_W'(p_q);
			REG_HEIGHT:  prdata = PDATA_W'(h_q);
			REG_WIDTH:   prdata = PDATA_W'(w_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		if (k_q == '0)
			k1 = KS_W'(1);
		else if (int'(k_q) > MAX_KERNEL)
			k1 = KS_W'(MAX_KERNEL);
		else
			k1 = k_q;
		eff.k = k1;
		eff.s = (s_q == '0) ? KS_W'(1) : s_q;
		eff.p = (p_q > k1 - 1'b1) ? (k1 - 1'b1) : p_q;
		if (h_q == '0)
			eff.h = DIM_W'(1);
		else if (int'(h_q) > MAX_HEIGHT)
			eff.h = DIM_W'(MAX_HEIGHT);
		else
			eff.h = h_q;
		if (w_q == '0)
			eff.w = DIM_W'(1);
		else if (int'(w_q) > MAX_WIDTH)
			eff.w = DIM_W'(MAX_WIDTH);
		else
			eff.w = w_q;
	end

	a_pad_below_k: assert property (@(posedge clk) disable iff (!arst_n)
		(eff.p < eff.k) && (eff.s != '0))
		else $error("working padding or stride out of range");

endmodule

>>> sv/dwc_datapath.sv
// Line store, tap weight memory and the shared multiply-accumulate pipeline.
module dwc_datapath #(
	parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF,
	localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH,
	localparam int SA_W        = $clog2(STORE_DEPTH),
	localparam int TAP_COUNT   = MAX_KERNEL * MAX_KERNEL,
	localparam int TW          = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        st_we,
	input  logic [SA_W-1:0]             st_waddr,
	input  logic [dwc_pkg::SMP_W-1:0]   st_wdata,
	input  logic                        wt_we,
	input  logic [TW-1:0]               wt_waddr,
	input  logic [dwc_pkg::SMP_W-1:0]   wt_wdata,
	input  dwc_pkg::mac_ctl_t           ctl,
	input  logic [SA_W-1:0]             st_raddr,
	input  logic [TW-1:0]               tap,
	input  logic [dwc_pkg::BIAS_W-1:0]  bias,
	output logic [dwc_pkg::ACC_W-1:0]   acc
);
	import dwc_pkg::*;

	logic [SMP_W-1:0]     store_mem [STORE_DEPTH];
	logic [SMP_W-1:0]     wt_mem    [TAP_COUNT];
	logic [TAP_COUNT-1:0] wt_vld_q;
	logic [SMP_W-1:0]     x_s1, w_s1;
	logic                 wv_s1;
	logic                 en_s1, use_s1, en_s2;
	logic [PROD_W-1:0]    prod_s2;
	logic [ACC_W-1:0]     acc_q;

	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_waddr] <= st_wdata;
		x_s1 <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (wt_we)
			wt_mem[wt_waddr] <= wt_wdata;
		w_s1  <= wt_mem[tap];
		wv_s1 <= wt_vld_q[tap];
	end

	// never-written taps read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wt_vld_q <= '0;
		else if (wt_we)
			wt_vld_q[wt_waddr] <= 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			use_s1 <= 1'b0;
			en_s2  <= 1'b0;
		end else begin
			en_s1  <= ctl.issue;
			use_s1 <= ctl.issue && ctl.use_tap;
			en_s2  <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (use_s1 && wv_s1)
			prod_s2 <= PROD_W'($signed(w_s1) * $signed(x_s1));
		else
			prod_s2 <= '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.init)
			acc_q <= {{(ACC_W-BIAS_W){bias[BIAS_W-1]}}, bias};
		else if (en_s2)
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	end

	assign acc = acc_q;

endmodule

>>> sv/depthwise_conv2d_stream_core.sv
// Top level: item sequencer, window range setup, output register.
// A weight or bias word needs no further work. A sample word first runs setup (an
// 11-step serial divide that locates the output pixels whose window the sample
// completes, then the line store write), then the taps of each such output pixel:
// every tap goes one per cycle through the single line store read port and the one
// shared multiplier. After reset the line store is cleared one entry per cycle,
// all MAX_KERNEL*MAX_WIDTH entries (1792 with the defaults), during which no word
// is taken; registers may be written meanwhile.
module depthwise_conv2d_stream_core #(
	parameter int MAX_KERNEL = dwc_pkg::MAX_KERNEL_DEF,
	parameter int MAX_HEIGHT = dwc_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = dwc_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dwc_pkg::PADDR_W-1:0]    paddr,
	input  logic [dwc_pkg::PDATA_W-1:0]    pwdata,
	output logic [dwc_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sample[15:0], tap_index[21:16], coefficient[37:22], bias_value[69:38], zero fill
	input  logic [dwc_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_row[7:0], out_col[15:8], result[55:16]
	output logic [dwc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	// plane_done[0]
	output logic                           m_tuser
);
	import dwc_pkg::*;

	localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int TAP_COUNT   = MAX_KERNEL * MAX_KERNEL;
	localparam int TW          = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int RP_W        = $clog2(MAX_HEIGHT);
	localparam int CP_W        = $clog2(MAX_WIDTH);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_WRITE = 7'b0001000,
		ST_TAPS  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	cfg_t              eff;
	state_t            state_q;
	logic [SA_W-1:0]   clr_q;
	logic [RP_W-1:0]   row_pos_q, r_eff;
	logic [CP_W-1:0]   col_pos_q, c_eff;
	logic              pos_out;
	logic              accept;
	kind_t             kind;
	logic [SMP_W-1:0]  smp_q;
	logic [BIAS_W-1:0] bias_q;
	snum_t             r_q, c_q, r_in, c_in;
	snum_t             nh, nw, tr, tc;
	logic              nh_neg_q, nw_neg_q, tr_neg_q, tc_neg_q;
	num_t              div_num [NDIV];
	logic [KS_W-1:0]   div_den [NDIV];
	div_res_t          div_res [NDIV];
	logic [NDIV-1:0]   div_done;
	logic              div_start;

	num_t              lo_r, hi_r, lo_c, hi_c;
	logic              ok_r, ok_c;
	num_t              hi_r_q, hi_c_q, lo_c_q, oh_last_q, ow_last_q;
	num_t              orow_q, ocol_q;
	snum_t             rbase_q, cbase_q, cbase0_q;
	logic [KS_W-1:0]   rk_q, kh_q, kw_q;
	logic [TW-1:0]     tap_q;
	logic              drain_q;

	snum_t             ir, ic, dr;
	logic              tap_in;
	logic [KS_W:0]     slot_w;
	logic [KS_W-1:0]   slot;
	logic [SA_W-1:0]   raddr, waddr;
	logic              st_we;
	logic [SA_W-1:0]   st_waddr;
	logic [SMP_W-1:0]  st_wdata;
	logic              wt_we;
	mac_ctl_t          ctl;
	logic [ACC_W-1:0]  acc;
	logic              out_free, out_load, last_pix;
	logic              m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	dwc_cfg #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.eff    (eff)
	);

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);

	// position outside the plane after a register change restarts at the origin
	assign pos_out = (int'(row_pos_q) >= int'(eff.h)) || (int'(col_pos_q) >= int'(eff.w));
	assign r_eff   = pos_out ? '0 : row_pos_q;
	assign c_eff   = pos_out ? '0 : col_pos_q;
	assign r_in    = snum_t'(r_eff);
	assign c_in    = snum_t'(c_eff);

	assign nh = snum_t'(eff.h) + snum_t'({eff.p, 1'b0}) - snum_t'(eff.k);
	assign nw = snum_t'(eff.w) + snum_t'({eff.p, 1'b0}) - snum_t'(eff.k);
	assign tr = r_in + snum_t'(eff.p) - snum_t'(eff.k) + snum_t'(1);
	assign tc = c_in + snum_t'(eff.p) - snum_t'(eff.k) + snum_t'(1);

	assign div_start = accept && (kind == KIND_SAMPLE);

	always_comb begin
		div_num[DIV_ROWS] = nh[NUM_W-1] ? '0 : num_t'(nh);
		div_num[DIV_COLS] = nw[NUM_W-1] ? '0 : num_t'(nw);
		div_num[DIV_TROW] = tr[NUM_W-1] ? '0 : num_t'(tr);
		div_num[DIV_TCOL] = tc[NUM_W-1] ? '0 : num_t'(tc);
		div_num[DIV_SLOT] = num_t'(r_in);
		div_den[DIV_ROWS] = eff.s;
		div_den[DIV_COLS] = eff.s;
		div_den[DIV_TROW] = eff.s;
		div_den[DIV_TCOL] = eff.s;
		div_den[DIV_SLOT] = eff.k;
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		dwc_div u_div (
			.clk   (clk),
			.arst_n(arst_n),
			.start (div_start),
			.num   (div_num[g]),
			.den   (div_den[g]),
			.done  (div_done[g]),
			.res   (div_res[g])
		);
	end

	// output rows and columns hit by this sample; on the last input row or column every
	// window clamped against that far edge is complete too
	always_comb begin
		lo_r = tr_neg_q ? '0 : div_res[DIV_TROW].quo + num_t'(div_res[DIV_TROW].rem != '0);
		lo_c = tc_neg_q ? '0 : div_res[DIV_TCOL].quo + num_t'(div_res[DIV_TCOL].rem != '0);
		if (r_q == snum_t'(eff.h) - snum_t'(1)) begin
			hi_r = div_res[DIV_ROWS].quo;
			ok_r = !nh_neg_q && (lo_r <= hi_r);
		end else begin
			lo_r = div_res[DIV_TROW].quo;
			hi_r = lo_r;
			ok_r = !nh_neg_q && !tr_neg_q && (div_res[DIV_TROW].rem == '0)
				&& (lo_r <= div_res[DIV_ROWS].quo);
		end
		if (c_q == snum_t'(eff.w) - snum_t'(1)) begin
			hi_c = div_res[DIV_COLS].quo;
			ok_c = !nw_neg_q && (lo_c <= hi_c);
		end else begin
			lo_c = div_res[DIV_TCOL].quo;
			hi_c = lo_c;
			ok_c = !nw_neg_q && !tc_neg_q && (div_res[DIV_TCOL].rem == '0)
				&& (lo_c <= div_res[DIV_COLS].quo);
		end
	end

	// tap address: row slot walks back from the sample row's slot
	assign ir     = rbase_q + snum_t'(kh_q);
	assign ic     = cbase_q + snum_t'(kw_q);
	assign dr     = r_q - ir;
	assign tap_in = !ir[NUM_W-1] && (ir < snum_t'(eff.h)) && (ir <= r_q)
		&& !ic[NUM_W-1] && (ic < snum_t'(eff.w));
	assign slot_w = ({1'b0, rk_q} >= {1'b0, dr[KS_W-1:0]})
		? ({1'b0, rk_q} - {1'b0, dr[KS_W-1:0]})
		: ({1'b0, rk_q} + {1'b0, eff.k} - {1'b0, dr[KS_W-1:0]});
	assign slot   = slot_w[KS_W-1:0];
	assign raddr  = SA_W'(int'(slot) * MAX_WIDTH + int'(ic));
	assign waddr  = SA_W'(int'(div_res[DIV_SLOT].rem) * MAX_WIDTH + int'(c_q));

	always_comb begin
		st_we    = 1'b0;
		st_waddr = clr_q;
		st_wdata = '0;
		if (state_q == ST_CLEAR) begin
			st_we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			st_we    = 1'b1;
			st_waddr = waddr;
			st_wdata = smp_q;
		end
	end

	assign wt_we = accept && (kind == KIND_WEIGHT) && (int'(s_tdata[21:16]) < TAP_COUNT);

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_EMIT) && out_free;
	assign last_pix = (orow_q == hi_r_q) && (ocol_q == hi_c_q);

	assign ctl.issue   = (state_q == ST_TAPS);
	assign ctl.use_tap = tap_in;
	assign ctl.init    = ((state_q == ST_WRITE) && ok_r && ok_c)
		|| (out_load && !last_pix);

	dwc_datapath #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.st_we   (st_we),
		.st_waddr(st_waddr),
		.st_wdata(st_wdata),
		.wt_we   (wt_we),
		.wt_waddr(TW'(s_tdata[21:16])),
		.wt_wdata(s_tdata[37:22]),
		.ctl     (ctl),
		.st_raddr(raddr),
		.tap     (tap_q),
		.bias    (bias_q),
		.acc     (acc)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			smp_q    <= s_tdata[15:0];
			r_q      <= r_in;
			c_q      <= c_in;
			nh_neg_q <= nh[NUM_W-1];
			nw_neg_q <= nw[NUM_W-1];
			tr_neg_q <= tr[NUM_W-1];
			tc_neg_q <= tc[NUM_W-1];
		end
		if (state_q == ST_WRITE) begin
			rk_q      <= div_res[DIV_SLOT].rem;
			hi_r_q    <= hi_r;
			hi_c_q    <= hi_c;
			lo_c_q    <= lo_c;
			oh_last_q <= div_res[DIV_ROWS].quo;
			ow_last_q <= div_res[DIV_COLS].quo;
			orow_q    <= lo_r;
			ocol_q    <= lo_c;
			rbase_q   <= snum_t'(int'(lo_r) * int'(eff.s) - int'(eff.p));
			cbase_q   <= snum_t'(int'(lo_c) * int'(eff.s) - int'(eff.p));
			cbase0_q  <= snum_t'(int'(lo_c) * int'(eff.s) - int'(eff.p));
		end else if (out_load && !last_pix) begin
			if (ocol_q != hi_c_q) begin
				ocol_q  <= ocol_q + 1'b1;
				cbase_q <= cbase_q + snum_t'(eff.s);
			end else begin
				orow_q  <= orow_q + 1'b1;
				rbase_q <= rbase_q + snum_t'(eff.s);
				ocol_q  <= lo_c_q;
				cbase_q <= cbase0_q;
			end
		end
		if (ctl.init) begin
			kh_q  <= '0;
			kw_q  <= '0;
			tap_q <= '0;
		end else if (state_q == ST_TAPS) begin
			tap_q <= tap_q + 1'b1;
			if (kw_q == eff.k - 1'b1) begin
				kw_q <= '0;
				kh_q <= kh_q + 1'b1;
			end else begin
				kw_q <= kw_q + 1'b1;
			end
		end
		if (out_load) begin
			m_tdata_q <= {acc, orow_q[COORD_W-1:0] & 8'h00 | ocol_q[COORD_W-1:0],
				orow_q[COORD_W-1:0]};
			m_tlast_q <= last_pix;
			m_tuser_q <= (orow_q == oh_last_q) && (ocol_q == ow_last_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			row_pos_q  <= '0;
			col_pos_q  <= '0;
			bias_q     <= '0;
			drain_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (accept && (kind == KIND_BIAS))
				bias_q <= s_tdata[69:38];
			if (div_start) begin
				if (int'(c_eff) + 1 >= int'(eff.w)) begin
					col_pos_q <= '0;
					row_pos_q <= (int'(r_eff) + 1 >= int'(eff.h)) ? '0
						: RP_W'(r_eff + 1'b1);
				end else begin
					col_pos_q <= CP_W'(c_eff + 1'b1);
					row_pos_q <= r_eff;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SA_W'(STORE_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (div_start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done[DIV_ROWS])
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= (ok_r && ok_c) ? ST_TAPS : ST_IDLE;
				end
				ST_TAPS: begin
					if ((kw_q == eff.k - 1'b1) && (kh_q == eff.k - 1'b1)) begin
						state_q <= ST_DRAIN;
						drain_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= last_pix ? ST_IDLE : ST_TAPS;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_no_store_write_in_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAPS) |-> !st_we)
		else $error("line store written while taps are read");

	a_pixel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAPS) |-> ((orow_q <= hi_r_q) && (ocol_q <= hi_c_q)))
		else $error("output pixel outside its range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_div_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && div_done[DIV_ROWS] |=> (state_q == ST_WRITE))
		else $error("setup did not follow the divide");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the depthwise convolution stream core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dwc_pkg::*;

	localparam int LIMIT_CYC  = 1000000;
	localparam int SETTLE_CYC = 2700;  // idle wait that covers the longest sample, with margin

	typedef struct packed {
		logic [1:0]  kind;
		logic [71:0] data;
	} word_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic [39:0] sum;
		logic        last;
		logic        done;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// sample[15:0], tap_index[21:16], coefficient[37:22], bias_value[69:38], zero fill
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// kind[1:0]
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// out_row[7:0], out_col[15:8], result[55:16]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	// plane_done[0]
	logic                  m_tuser;

	depthwise_conv2d_stream_core uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the block: registers, line store, taps, bias, write position
	int            cfg_k = 3, cfg_s = 1, cfg_p = 1, cfg_h = 256, cfg_w = 256;
	logic [15:0]   rows_mem [0:7*256-1];
	logic [15:0]   taps [0:48];
	logic [31:0]   bias_r;
	int            row_pos, col_pos;

	word_t  pend [$];
	pixel_t pixels_due [$];
	int     errors = 0, n_samples = 0, n_pixels = 0, n_phases = 0, n_queued = 0;
	bit     calm = 1'b0;

	function automatic int plane_out(int n, int p, int k, int s);
		if (n + 2 * p < k)
			return 0;
		return (n + 2 * p - k) / s + 1;
	endfunction

	function automatic int last_row_of(int o, int s, int p, int k, int n);
		int b;
		b = o * s - p + k - 1;
		return (b > n - 1) ? n - 1 : b;
	endfunction

	function automatic void conv_sample(logic [15:0] smp);
		int     k, s, p, h, w, ohn, own, r, c, nr, nc, ir, ic, cnt;
		int     rows [8];
		int     cols [8];
		longint acc;
		pixel_t px;
		k = (cfg_k < 1) ? 1 : cfg_k;
		s = (cfg_s < 1) ? 1 : cfg_s;
		p = (cfg_p > k - 1) ? k - 1 : cfg_p;
		h = (cfg_h < 1) ? 1 : (cfg_h > 256 ? 256 : cfg_h);
		w = (cfg_w < 1) ? 1 : (cfg_w > 256 ? 256 : cfg_w);
		if (row_pos >= h || col_pos >= w) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		rows_mem[(r % k) * 256 + c] = smp;
		ohn = plane_out(h, p, k, s);
		own = plane_out(w, p, k, s);
		nr = 0;
		nc = 0;
		cnt = 0;
		for (int o = 0; o < ohn; o++)
			if (last_row_of(o, s, p, k, h) == r && nr < 8) begin
				rows[nr] = o;
				nr++;
			end
		for (int o = 0; o < own; o++)
			if (last_row_of(o, s, p, k, w) == c && nc < 8) begin
				cols[nc] = o;
				nc++;
			end
		for (int i = 0; i < nr; i++)
			for (int j = 0; j < nc; j++) begin
				acc = longint'($signed(bias_r));
				for (int kh = 0; kh < k; kh++) begin
					ir = rows[i] * s - p + kh;
					if (ir < 0 || ir >= h || ir > r)
						continue;
					for (int kw = 0; kw < k; kw++) begin
						ic = cols[j] * s - p + kw;
						if (ic < 0 || ic >= w)
							continue;
						acc += longint'($signed(taps[kh * k + kw]))
							* longint'($signed(rows_mem[(ir % k) * 256 + ic]));
					end
				end
				px.row = rows[i][7:0];
				px.col = cols[j][7:0];
				px.sum = acc[39:0];
				px.last = 1'b0;
				px.done = (rows[i] == ohn - 1 && cols[j] == own - 1);
				pixels_due.push_back(px);
				cnt++;
			end
		if (cnt > 0)
			pixels_due[pixels_due.size() - 1].last = 1'b1;
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		n_samples++;
	endfunction

	function automatic void predict(word_t wd);
		case (wd.kind)
			KIND_WEIGHT: if (wd.data[21:16] < 49) taps[wd.data[21:16]] = wd.data[37:22];
			KIND_BIAS: bias_r = wd.data[69:38];
			KIND_SAMPLE: conv_sample(wd.data[15:0]);
			default: ;
		endcase
	endfunction

	// unused fields carry random bits
	function automatic word_t make_word(logic [1:0] kind);
		word_t wd;
		wd.kind = kind;
		wd.data = {2'b00, $urandom(), $urandom(), 8'($urandom())};
		return wd;
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic add_sample(logic [15:0] v);
		word_t wd;
		wd = make_word(KIND_SAMPLE);
		wd.data[15:0] = v;
		pend.push_back(wd);
		n_queued++;
	endtask

	task automatic add_tap(logic [5:0] idx, logic [15:0] v);
		word_t wd;
		wd = make_word(KIND_WEIGHT);
		wd.data[21:16] = idx;
		wd.data[37:22] = v;
		pend.push_back(wd);
	endtask

	task automatic add_bias(logic [31:0] v);
		word_t wd;
		wd = make_word(KIND_BIAS);
		wd.data[69:38] = v;
		pend.push_back(wd);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KERNEL: cfg_k = v[2:0];
			REG_STRIDE: cfg_s = v[2:0];
			REG_PADDING: cfg_p = v[2:0];
			REG_HEIGHT: cfg_h = v[8:0];
			REG_WIDTH: cfg_w = v[8:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		wait (pend.size() == 0 && !s_tvalid && pixels_due.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_plane(int k, int s, int p, int h, int w);
		reg_write(REG_KERNEL, k);
		reg_write(REG_STRIDE, s);
		reg_write(REG_PADDING, p);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_WIDTH, w);
		n_phases++;
	endtask

	// full tap set, sometimes a stray tap index or kind 3 word, a bias, then n samples
	task automatic run_plane(int n);
		for (int t = 0; t < 49; t++)
			add_tap(t, pick16());
		if ($urandom_range(0, 2) == 0)
			add_tap($urandom_range(49, 63), pick16());
		if ($urandom_range(0, 2) == 0)
			pend.push_back(make_word(2'd3));
		add_bias($urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom());
		for (int i = 0; i < n; i++)
			add_sample(pick16());
		wait_idle();
	endtask

	// sender
	int    tx_gap = 0;
	word_t tx_cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict(tx_cur);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pend.size() > 0) begin
					tx_cur = pend.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= tx_cur.data;
					s_tuser <= tx_cur.kind;
					if (!calm)
						tx_gap = ($urandom_range(0, 9) < 5) ? 0 :
							($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) :
							$urandom_range(10, 60);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	int     rx_hold = 0;
	bit     long_done = 1'b0;
	pixel_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[15:8], m_tdata[55:16], m_tlast, m_tuser};
				n_pixels++;
				if (pixels_due.size() == 0) begin
					errors++;
					$display("%0t unexpected word: row %0d col %0d sum %0d", $time,
						got.row, got.col, $signed(got.sum));
				end else begin
					want = pixels_due.pop_front();
					if (got != want) begin
						errors++;
						$display("%0t mismatch exp row %0d col %0d sum %0d last %0b done %0b",
							$time, want.row, want.col, $signed(want.sum), want.last, want.done);
						$display("%0t          got row %0d col %0d sum %0d last %0b done %0b",
							$time, got.row, got.col, $signed(got.sum), got.last, got.done);
					end
				end
			end
			// one long hold-off so the core backs up into its input
			if (!long_done && n_pixels == 30) begin
				long_done = 1'b1;
				rx_hold = 1500;
			end else if (rx_hold == 0 && !calm && $urandom_range(0, 199) == 0) begin
				rx_hold = $urandom_range(10, 60);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYC) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int h, w;
		for (int i = 0; i < 7 * 256; i++)
			rows_mem[i] = '0;
		for (int i = 0; i < 49; i++)
			taps[i] = '0;
		bias_r = '0;
		row_pos = 0;
		col_pos = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 3x3 kernel on a 3x4 plane, extreme taps, ignored words
		set_plane(3, 1, 1, 3, 4);
		for (int t = 0; t < 9; t++)
			add_tap(t, (t % 2) ? 16'h8000 : 16'h7fff);
		add_tap(6'd49, 16'h1234);
		add_tap(6'd63, 16'h4321);
		pend.push_back(make_word(2'd3));
		add_bias(32'h7fff_ffff);
		for (int i = 0; i < 12; i++)
			add_sample(i % 3 == 0 ? 16'h8000 : (i % 3 == 1 ? 16'h7fff : 16'h0000));
		wait_idle();

		set_plane(1, 1, 0, 1, 1);
		run_plane(3);
		calm = 1'b1;
		set_plane(7, 7, 6, 7, 7);
		run_plane(49);
		calm = 1'b0;
		set_plane(7, 1, 6, 8, 8);
		run_plane(64);
		set_plane(2, 3, 1, 6, 9);
		run_plane(54);
		// tall plane left unfinished, then shrunk: write position falls outside
		set_plane(1, 1, 0, 256, 1);
		run_plane(40);
		set_plane(0, 0, 7, 0, 0);
		run_plane(3);
		set_plane(5, 2, 7, 300, 3);
		run_plane(20);
		set_plane(4, 1, 2, 3, 256);
		run_plane(30);
		set_plane(3, 1, 1, 511, 511);
		run_plane(10);

		while (n_queued < 460) begin
			calm = ($urandom_range(0, 3) == 0);
			h = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 7);
			w = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 7);
			set_plane($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7), h, w);
			run_plane((h < 1 ? 1 : h) * (w < 1 ? 1 : w) + $urandom_range(0, 6));
		end
		calm = 1'b0;
		wait_idle();

		$display("covered %0d register settings, %0d samples, %0d output pixels checked",
			n_phases, n_samples, n_pixels);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
